// ===== rtl/aes128_pkg.sv =====
// Shared types, constants and round functions for the AES-128 cipher.
`default_nettype none
package aes128_pkg;

    localparam int ROUNDS = 10;

    typedef logic [ROUNDS:0][127:0] t_rk_array;

    typedef struct packed {
        logic valid;
        logic cmd;
    } t_ctl;

    localparam logic CMD_ENCRYPT = 1'b0;

    localparam logic [0:255][7:0] FWD_SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

    localparam logic [0:255][7:0] INV_SBOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int n = 0; n < 16; n++) begin
            r[127-8*n -: 8] = inv ? INV_SBOX[s[127-8*n -: 8]] : FWD_SBOX[s[127-8*n -: 8]];
        end
        sub_bytes = r;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        int src;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                src = inv ? ((c - k + 4) & 3) : ((c + k) & 3);
                r[127-8*(4*c+k) -: 8] = s[127-8*(4*src+k) -: 8];
            end
        end
        shift_rows = r;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] acc;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j] = s[127-8*(4*c+j) -: 8];
                x2[j] = xtime(a[j]);
                x4[j] = xtime(x2[j]);
                x8[j] = xtime(x4[j]);
            end
            for (int k = 0; k < 4; k++) begin
                if (inv) begin
                    acc = (x8[k] ^ x4[k] ^ x2[k])
                        ^ (x8[(k+1)&3] ^ x2[(k+1)&3] ^ a[(k+1)&3])
                        ^ (x8[(k+2)&3] ^ x4[(k+2)&3] ^ a[(k+2)&3])
                        ^ (x8[(k+3)&3] ^ a[(k+3)&3]);
                end else begin
                    acc = x2[k] ^ (x2[(k+1)&3] ^ a[(k+1)&3]) ^ a[(k+2)&3] ^ a[(k+3)&3];
                end
                r[127-8*(4*c+k) -: 8] = acc;
            end
        end
        mix_columns = r;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] p,
                                                    input logic [7:0] rcon);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t = {FWD_SBOX[p[23:16]], FWD_SBOX[p[15:8]], FWD_SBOX[p[7:0]], FWD_SBOX[p[31:24]]}
            ^ {rcon, 24'h000000};
        w0 = p[127:96] ^ t;
        w1 = p[95:64] ^ w0;
        w2 = p[63:32] ^ w1;
        w3 = p[31:0] ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/aes128_key_exp.sv =====
// Key schedule unit that expands the cipher key one round key per cycle.
`default_nettype none
module aes128_key_exp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_restart,
    input  wire logic [127:0]         i_key,
    output aes128_pkg::t_rk_array     o_round_keys,
    output logic                      o_ready
);

    aes128_pkg::t_rk_array r_rk;
    logic [127:0] r_prev;
    logic [7:0]   r_rcon;
    logic [3:0]   r_cnt;
    logic         r_busy;
    logic         r_ready;
    logic [127:0] n_key;

    assign n_key = aes128_pkg::next_round_key(r_prev, r_rcon);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_ready <= 1'b0;
            r_cnt   <= 4'd0;
        end else if (i_restart) begin
            r_busy  <= 1'b0;
            r_ready <= 1'b0;
        end else if (!r_ready && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd1;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'(aes128_pkg::ROUNDS)) begin
                r_busy  <= 1'b0;
                r_ready <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ready && !r_busy) begin
            r_rk[0] <= i_key;
            r_prev  <= i_key;
            r_rcon  <= 8'h01;
        end else if (r_busy) begin
            r_rk[r_cnt] <= n_key;
            r_prev      <= n_key;
            r_rcon      <= aes128_pkg::xtime(r_rcon);
        end
    end

    assign o_round_keys = r_rk;
    assign o_ready      = r_ready;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_ready) else $error("key schedule busy while marked ready");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt >= 4'd1 && r_cnt <= 4'(aes128_pkg::ROUNDS)))
        else $error("key schedule counter out of range");

    a_ready_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready && !i_restart |=> r_ready) else $error("round keys lost without a key write");

endmodule
`default_nettype wire

// ===== rtl/aes128_round.sv =====
// One registered cipher round stage, forward or inverse per item.
`default_nettype none
module aes128_round (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_last,
    input  wire aes128_pkg::t_ctl     i_ctl,
    input  wire logic [127:0]         i_state,
    input  wire logic [127:0]         i_enc_key,
    input  wire logic [127:0]         i_dec_key,
    output aes128_pkg::t_ctl          o_ctl,
    output logic [127:0]              o_state
);

    aes128_pkg::t_ctl r_ctl;
    logic [127:0] r_state;
    logic [127:0] n_state;
    logic [127:0] enc_sr;
    logic [127:0] enc_mc;
    logic [127:0] dec_sb;
    logic [127:0] dec_ak;

    always_comb begin
        enc_sr = aes128_pkg::shift_rows(aes128_pkg::sub_bytes(i_state, 1'b0), 1'b0);
        enc_mc = i_last ? enc_sr : aes128_pkg::mix_columns(enc_sr, 1'b0);
        dec_sb = aes128_pkg::sub_bytes(aes128_pkg::shift_rows(i_state, 1'b1), 1'b1);
        dec_ak = dec_sb ^ i_dec_key;
        if (i_ctl.cmd == aes128_pkg::CMD_ENCRYPT) begin
            n_state = enc_mc ^ i_enc_key;
        end else begin
            n_state = i_last ? dec_ak : aes128_pkg::mix_columns(dec_ak, 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;

endmodule
`default_nettype wire

// ===== rtl/aes128_block_cipher.sv =====
// AES-128 encrypt and decrypt engine: top level with key registers and round pipeline.
// A block is taken on start while busy is low and its result appears with the valid
// strobe after the input register and round stages; each round is a registered stage,
// so a new block can enter every cycle while busy is low. After reset and after each
// key write the key schedule runs one round key per cycle, holding busy high until
// all round keys are ready. Results cannot be held off by the receiver.
`default_nettype none
module aes128_block_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_cmd,
    input  wire logic [63:0] i_block_in_high,
    input  wire logic [63:0] i_block_in_low,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output logic             o_valid,
    output logic [63:0]      o_block_out_high,
    output logic [63:0]      o_block_out_low
);

    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
    localparam int ROUNDS = aes128_pkg::ROUNDS;

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic        key_write;
    logic        keys_ready;
    logic        accept;
    aes128_pkg::t_rk_array round_keys;
    aes128_pkg::t_ctl r_in_ctl;
    logic [127:0] r_in_state;
    aes128_pkg::t_ctl ctl [ROUNDS+1];
    logic [127:0] st [ROUNDS+1];

    assign key_write = i_cfg_wr_en && (i_cfg_index == CFG_KEY_HIGH || i_cfg_index == CFG_KEY_LOW);
    assign o_busy    = !keys_ready;
    assign accept    = i_start && keys_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aes128_key_exp u_key_exp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (key_write),
        .i_key        ({r_key_high, r_key_low}),
        .o_round_keys (round_keys),
        .o_ready      (keys_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else begin
            r_in_ctl <= '{valid: accept, cmd: i_cmd};
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_state <= {i_block_in_high, i_block_in_low}
            ^ ((i_cmd == aes128_pkg::CMD_ENCRYPT) ? round_keys[0] : round_keys[ROUNDS]);
    end

    assign ctl[0] = r_in_ctl;
    assign st[0]  = r_in_state;

    for (genvar j = 1; j <= ROUNDS; j++) begin : g_round
        aes128_round u_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_last    (1'(j == ROUNDS)),
            .i_ctl     (ctl[j-1]),
            .i_state   (st[j-1]),
            .i_enc_key (round_keys[j]),
            .i_dec_key (round_keys[ROUNDS-j]),
            .o_ctl     (ctl[j]),
            .o_state   (st[j])
        );
    end

    assign o_valid          = ctl[ROUNDS].valid;
    assign o_block_out_high = st[ROUNDS][127:64];
    assign o_block_out_low  = st[ROUNDS][63:0];

endmodule
`default_nettype wire
